// ===== sv/ieu_pkg.sv =====
package ieu_pkg;

    localparam int DEF_MEM_BYTES = 4096;
    localparam int WORD_BYTES    = 8;
    localparam int XLEN          = 64;

    typedef enum logic [9:0] {
        OP_LOADI  = 10'd0,
        OP_MOV    = 10'd1,
        OP_ADD    = 10'd2,
        OP_SUB    = 10'd3,
        OP_MULT   = 10'd4,
        OP_DIV    = 10'd5,
        OP_BR     = 10'd6,
        OP_BRNEG  = 10'd7,
        OP_BRZERO = 10'd8,
        OP_BREQ   = 10'd9,
        OP_BRLT   = 10'd10,
        OP_BRLE   = 10'd11,
        OP_BRGT   = 10'd12,
        OP_BRGE   = 10'd13,
        OP_CMP    = 10'd14,
        OP_LOAD   = 10'd15,
        OP_STORE  = 10'd16,
        OP_LOADA  = 10'd17,
        OP_LOADR  = 10'd18,
        OP_STORER = 10'd19,
        OP_INC    = 10'd20,
        OP_DEC    = 10'd21,
        OP_NOP    = 10'd22,
        OP_HALT   = 10'd23
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HALT    = 3'd1,
        ST_DIVZERO = 3'd2,
        ST_BADADDR = 3'd3,
        ST_UNKNOWN = 3'd4,
        ST_STOPPED = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_MEMRD,
        S_MEMWR,
        S_WB,
        S_OUT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic latch;
        logic read_regs;
        logic exec;
        logic mul_step;
        logic div_start;
        logic div_step;
        logic mem_rd_step;
        logic mem_wr_step;
        logic writeback;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic stopped;
        logic need_mul;
        logic need_div;
        logic need_rd;
        logic need_wr;
        logic unit_done;
    } stat_t;

endpackage

// ===== sv/instruction_execute_unit.sv =====
// Executes one decoded instruction per input beat and returns one result beat.
// After a beat is accepted, read, execute and writeback states lead to the output
// state, which raises m_tvalid; loads and stores add a memory state, multiply and
// divide their bit-serial shift-add and restoring-division loops. No new beat is
// taken until the result is accepted; once stopped, a beat skips execution. After
// reset a clearing pass zeroes every memory word and all 32 registers (one memory
// word and one register per cycle), and no beat is accepted until it ends;
// start_pc writes are accepted every cycle and belong where no instruction is in
// flight.
module instruction_execute_unit #(
    parameter int MEM_BYTES = ieu_pkg::DEF_MEM_BYTES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // func, dest_reg, src_reg_a, src_reg_b, immediate
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // status, next_pc, zero, negative, dest_value
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [63:0]  cfg_data
);
    import ieu_pkg::*;

    cmd_t  cmd;
    stat_t st;

    assign cfg_ready = 1'b1;

    ieu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ieu_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .in_data  (s_tdata[56:0]),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .out_data (m_tdata)
    );

endmodule

// ===== sv/ieu_ctrl.sv =====
module ieu_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  ieu_pkg::stat_t st,
    output ieu_pkg::cmd_t  cmd
);
    import ieu_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (st.clear_done) state_next = S_IDLE;
            S_IDLE:  if (s_tvalid) state_next = S_READ;
            S_READ:  state_next = st.stopped ? S_OUT : S_EXEC;
            S_EXEC:
            begin
                if (st.need_mul)      state_next = S_MUL;
                else if (st.need_div) state_next = S_DIV;
                else if (st.need_rd)  state_next = S_MEMRD;
                else if (st.need_wr)  state_next = S_MEMWR;
                else                  state_next = S_WB;
            end
            S_MUL:   if (st.unit_done) state_next = S_WB;
            S_DIV:   if (st.unit_done) state_next = S_WB;
            S_MEMRD: if (st.unit_done) state_next = S_WB;
            S_MEMWR: if (st.unit_done) state_next = S_WB;
            S_WB:    state_next = S_OUT;
            S_OUT:   if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            S_CLEAR: cmd.clear_step = 1'b1;
            S_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
            end
            S_READ:  cmd.read_regs = 1'b1;
            S_EXEC:
            begin
                cmd.exec      = 1'b1;
                cmd.div_start = st.need_div;
            end
            S_MUL:   cmd.mul_step = 1'b1;
            S_DIV:   cmd.div_step = 1'b1;
            S_MEMRD: cmd.mem_rd_step = 1'b1;
            S_MEMWR: cmd.mem_wr_step = 1'b1;
            S_WB:    cmd.writeback = 1'b1;
            S_OUT:   m_tvalid = 1'b1;
            default: cmd = '0;
        endcase
        cmd.out_load = (state_reg == S_READ && st.stopped) || state_reg == S_WB;
    end

endmodule

// ===== sv/ieu_dp.sv =====
module ieu_dp #(
    parameter int MEM_BYTES = ieu_pkg::DEF_MEM_BYTES
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ieu_pkg::cmd_t  cmd,
    output ieu_pkg::stat_t st,
    input  logic [56:0]    in_data,
    input  logic           cfg_we,
    input  logic [63:0]    cfg_data,
    output logic [135:0]   out_data
);
    import ieu_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam int WW = AW - 3;
    localparam int WORDS = MEM_BYTES / WORD_BYTES;
    localparam int CLR_N = (WORDS > 32) ? WORDS : 32;
    localparam int CW = $clog2(CLR_N);

    logic [63:0] rf [32];
    logic [63:0] mem [WORDS];

    logic [9:0]  func_reg;
    logic [4:0]  rd_reg, ra_reg, rb_reg;
    logic [63:0] imm_reg;
    logic [63:0] a_reg, b_reg, d_reg;
    logic [63:0] pc_reg;
    logic        z_reg, n_reg, stopped_reg;
    logic [63:0] res_reg;
    logic        wr_rf_reg, wr_fl_reg;
    logic [2:0]  status_reg;
    logic [63:0] addr_reg;
    logic [CW:0] clr_reg;
    logic [63:0] acc_reg, mc_reg, mp_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] q_reg, r_reg, dvs_reg;
    logic        qneg_reg;
    logic [63:0] rdata_reg;
    logic [135:0] out_reg;

    logic        addr_bad;
    logic [63:0] amag, bmag;
    logic [64:0] rtrial;
    logic [63:0] rsh;
    logic [63:0] qfinal;
    logic [63:0] target;
    logic        take;
    logic [AW-1:0] addr_lo;
    logic [WW-1:0] waddr;
    logic        aligned;
    logic [63:0] commit_val;
    logic        commit_nf, commit_zf;

    assign st.clear_done = clr_reg == (CW+1)'(CLR_N - 1);
    assign st.stopped    = stopped_reg;
    assign st.need_mul   = func_reg == OP_MULT;
    assign st.need_div   = func_reg == OP_DIV && b_reg != 64'd0;
    assign st.need_rd    = (func_reg == OP_LOAD || func_reg == OP_LOADR) && !addr_bad;
    assign st.need_wr    = (func_reg == OP_STORE || func_reg == OP_STORER) && !addr_bad;
    assign st.unit_done  = cnt_reg == 7'd0;

    assign amag   = a_reg[63] ? (~a_reg + 64'd1) : a_reg;
    assign bmag   = b_reg[63] ? (~b_reg + 64'd1) : b_reg;
    assign rsh    = {r_reg[62:0], q_reg[63]};
    assign rtrial = {1'b0, rsh} - {1'b0, dvs_reg};
    assign qfinal = qneg_reg ? (~q_reg + 64'd1) : q_reg;
    assign target = pc_reg + {imm_reg[60:0], 3'b000};
    assign addr_lo = addr_reg[AW-1:0];
    assign waddr  = addr_lo[AW-1:3];
    assign aligned = addr_lo[2:0] == 3'd0;

    always_comb
    begin
        addr_bad = addr_reg[63] || (addr_reg > 64'(MEM_BYTES - WORD_BYTES));
        case (func_reg)
            OP_BR:                take = 1'b1;
            OP_BRNEG, OP_BRLT:    take = n_reg;
            OP_BRZERO, OP_BREQ:   take = z_reg;
            OP_BRLE:              take = n_reg | z_reg;
            OP_BRGT:              take = !n_reg && !z_reg;
            OP_BRGE:              take = !n_reg;
            default:              take = 1'b0;
        endcase
    end

    // byte memory held as 8-byte words; unaligned access spans two words
    logic [63:0] mlo_reg;
    logic [127:0] pair;
    logic [5:0] sh;
    assign sh = {addr_lo[2:0], 3'b000};
    assign pair = {rdata_reg, mlo_reg} >> sh;

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step && clr_reg < (CW+1)'(WORDS))
        begin
            mem[clr_reg[WW-1:0]] <= '0;
        end
        else if (cmd.mem_wr_step)
        begin
            if (cnt_reg == 7'd3)
            begin
                mlo_reg <= mem[waddr];
            end
            else if (cnt_reg == 7'd2)
            begin
                rdata_reg <= aligned ? 64'd0 : mem[waddr + WW'(1)];
            end
            else if (cnt_reg == 7'd1)
            begin
                mem[waddr] <= (mlo_reg & ~(64'hFFFF_FFFF_FFFF_FFFF << sh))
                              | (d_reg << sh);
            end
            else
            begin
                if (!aligned)
                begin
                    mem[waddr + WW'(1)] <= (rdata_reg & (64'hFFFF_FFFF_FFFF_FFFF << sh))
                                           | (d_reg >> (7'd64 - {1'b0, sh}));
                end
            end
        end
        else if (cmd.mem_rd_step)
        begin
            if (cnt_reg == 7'd2)
            begin
                mlo_reg <= mem[waddr];
            end
            else if (cnt_reg == 7'd1)
            begin
                rdata_reg <= aligned ? 64'd0 : mem[waddr + WW'(1)];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= '0;
            pc_reg      <= '0;
            z_reg       <= 1'b0;
            n_reg       <= 1'b0;
            stopped_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                pc_reg <= cfg_data;
            end
            if (cmd.exec)
            begin
                pc_reg <= take ? target : pc_reg + 64'd8;
                if (st.need_mul)      cnt_reg <= 7'd63;
                else if (st.need_div) cnt_reg <= 7'd63;
                else if (st.need_rd)  cnt_reg <= 7'd2;
                else if (st.need_wr)  cnt_reg <= 7'd3;
            end
            if ((cmd.mul_step || cmd.div_step || cmd.mem_rd_step || cmd.mem_wr_step)
                && cnt_reg != 7'd0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.writeback)
            begin
                if (status_reg != ST_OK)
                begin
                    stopped_reg <= 1'b1;
                end
                else if (wr_fl_reg)
                begin
                    n_reg <= commit_nf;
                    z_reg <= commit_zf;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg <= in_data[9:0];
            rd_reg   <= in_data[14:10];
            ra_reg   <= in_data[19:15];
            rb_reg   <= in_data[24:20];
            imm_reg  <= {{32{in_data[56]}}, in_data[56:25]};
        end
        if (cmd.read_regs)
        begin
            a_reg <= rf[ra_reg];
            b_reg <= rf[rb_reg];
            d_reg <= rf[rd_reg];
            addr_reg <= (func_reg == OP_LOADR || func_reg == OP_STORER)
                        ? rf[ra_reg] : imm_reg;
        end
        if (cmd.exec)
        begin
            wr_rf_reg  <= 1'b0;
            wr_fl_reg  <= 1'b0;
            status_reg <= ST_OK;
            res_reg    <= d_reg;
            case (func_reg)
                OP_LOADI, OP_LOADA: begin res_reg <= imm_reg; wr_rf_reg <= 1'b1; end
                OP_MOV: begin res_reg <= a_reg; wr_rf_reg <= 1'b1; end
                OP_ADD: begin res_reg <= a_reg + b_reg; wr_rf_reg <= 1'b1; end
                OP_SUB:
                begin
                    res_reg <= a_reg - b_reg; wr_rf_reg <= 1'b1; wr_fl_reg <= 1'b1;
                end
                OP_CMP: begin res_reg <= a_reg - b_reg; wr_fl_reg <= 1'b1; end
                OP_INC:
                begin
                    res_reg <= d_reg + 64'd1; wr_rf_reg <= 1'b1; wr_fl_reg <= 1'b1;
                end
                OP_DEC:
                begin
                    res_reg <= d_reg - 64'd1; wr_rf_reg <= 1'b1; wr_fl_reg <= 1'b1;
                end
                OP_MULT:
                begin
                    acc_reg <= '0; mc_reg <= a_reg; mp_reg <= b_reg;
                    wr_rf_reg <= 1'b1; wr_fl_reg <= 1'b1;
                end
                OP_DIV:
                begin
                    if (b_reg == 64'd0) status_reg <= ST_DIVZERO;
                    else begin wr_rf_reg <= 1'b1; wr_fl_reg <= 1'b1; end
                end
                OP_LOAD, OP_LOADR:
                begin
                    if (addr_bad) status_reg <= ST_BADADDR;
                    else wr_rf_reg <= 1'b1;
                end
                OP_STORE, OP_STORER: if (addr_bad) status_reg <= ST_BADADDR;
                OP_BR, OP_BRNEG, OP_BRZERO, OP_BREQ, OP_BRLT, OP_BRLE, OP_BRGT,
                OP_BRGE, OP_NOP: status_reg <= ST_OK;
                OP_HALT: status_reg <= ST_HALT;
                default: status_reg <= ST_UNKNOWN;
            endcase
        end
        if (cmd.div_start)
        begin
            q_reg    <= amag;
            r_reg    <= '0;
            dvs_reg  <= bmag;
            qneg_reg <= a_reg[63] ^ b_reg[63];
        end
        if (cmd.mul_step)
        begin
            if (mp_reg[0]) acc_reg <= acc_reg + mc_reg;
            mc_reg <= {mc_reg[62:0], 1'b0};
            mp_reg <= {1'b0, mp_reg[63:1]};
            if (cnt_reg == 7'd0) res_reg <= mp_reg[0] ? acc_reg + mc_reg : acc_reg;
        end
        if (cmd.div_step)
        begin
            if (!rtrial[64])
            begin
                r_reg <= rtrial[63:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= rsh;
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
        if (cmd.mem_rd_step && cnt_reg == 7'd0)
        begin
            res_reg <= pair[63:0];
        end
        if (cmd.writeback)
        begin
            if (func_reg == OP_DIV && status_reg == ST_OK)
            begin
                res_reg <= qfinal;
            end
        end
    end

    // commit stage: register file write and result capture
    always_comb
    begin
        commit_val = (func_reg == OP_DIV && status_reg == ST_OK) ? qfinal : res_reg;
        commit_nf  = (wr_fl_reg && status_reg == ST_OK) ? commit_val[63] : n_reg;
        commit_zf  = (wr_fl_reg && status_reg == ST_OK) ? commit_val == 64'd0 : z_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step && clr_reg < (CW+1)'(32))
        begin
            rf[clr_reg[4:0]] <= '0;
        end
        else if (cmd.writeback && wr_rf_reg && status_reg == ST_OK)
        begin
            rf[rd_reg] <= commit_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.writeback)
        begin
            out_reg <= {3'd0,
                        (wr_rf_reg && status_reg == ST_OK) ? commit_val : d_reg,
                        commit_nf, commit_zf, pc_reg, status_reg};
        end
        else if (cmd.out_load && stopped_reg)
        begin
            out_reg <= {3'd0, rf[rd_reg], n_reg, z_reg, pc_reg, ST_STOPPED};
        end
    end

    assign out_data = out_reg;

endmodule

// ===== sv/ieu_checker.sv =====
module ieu_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input open while result pending");
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= 3'd5)
        else $error("bad status code");
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !m_tvalid)
        else $error("result too early");
endmodule

bind instruction_execute_unit ieu_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ieu_pkg::*;

    localparam int DMEM_BYTES = DEF_MEM_BYTES;
    localparam int TIME_LIMIT = 2000000;
    localparam int RAND_ITEMS = 1500;

    typedef struct packed {
        status_t     status;
        logic [63:0] pc;
        logic        zf;
        logic        nf;
        logic [63:0] value;
    } retire_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;   // func, dest_reg, src_reg_a, src_reg_b, immediate
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;   // status, next_pc, zero, negative, dest_value
    logic         cfg_valid;
    logic         cfg_ready;
    logic [63:0]  cfg_data;

    logic [63:0] regs [32];
    logic        zflag;
    logic        nflag;
    logic [63:0] pc;
    logic        halted;
    logic [7:0]  dmem [DMEM_BYTES];

    retire_t     retire_q [$];
    int          errors;
    int          beats_out;
    int          cycles;
    int          hold_off;
    bit          quiet;
    int          kind_seen [24];

    instruction_execute_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > TIME_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results pending", cycles,
                         retire_q.size());
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    function automatic bit addr_valid(logic [63:0] a);
        return !a[63] && a <= 64'(DMEM_BYTES - 8);
    endfunction

    function automatic logic [63:0] abs64(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    task automatic set_flags(logic [63:0] v);
        nflag = v[63];
        zflag = (v == 64'd0);
    endtask

    task automatic execute(input logic [63:0] beat, output retire_t r);
        logic [9:0]  f;
        logic [4:0]  rd, ra, rb;
        logic [63:0] imm, a, b, target, q, w;
        status_t     st;
        bit          take;
        f    = beat[9:0];
        rd   = beat[14:10];
        ra   = beat[19:15];
        rb   = beat[24:20];
        imm  = {{32{beat[56]}}, beat[56:25]};
        st   = ST_OK;
        take = 1'b0;
        if (halted)
            st = ST_STOPPED;
        else
        begin
            if (f < 24)
                kind_seen[f]++;
            target = pc + (imm << 3);
            pc     = pc + 64'd8;
            a      = regs[ra];
            b      = regs[rb];
            case (f)
                OP_LOADI, OP_LOADA: regs[rd] = imm;
                OP_MOV:    regs[rd] = a;
                OP_ADD:    regs[rd] = a + b;
                OP_SUB:    begin regs[rd] = a - b; set_flags(regs[rd]); end
                OP_MULT:   begin regs[rd] = a * b; set_flags(regs[rd]); end
                OP_DIV:
                    if (b == 64'd0)
                        st = ST_DIVZERO;
                    else
                    begin
                        q = abs64(a) / abs64(b);
                        regs[rd] = (a[63] != b[63]) ? -q : q;
                        set_flags(regs[rd]);
                    end
                OP_BR:               take = 1'b1;
                OP_BRNEG, OP_BRLT:   take = nflag;
                OP_BRZERO, OP_BREQ:  take = zflag;
                OP_BRLE:             take = nflag || zflag;
                OP_BRGT:             take = !nflag && !zflag;
                OP_BRGE:             take = !nflag;
                OP_CMP:              set_flags(a - b);
                OP_LOAD, OP_LOADR:
                begin
                    w = (f == OP_LOAD) ? imm : a;
                    if (!addr_valid(w))
                        st = ST_BADADDR;
                    else
                        for (int i = 0; i < 8; i++)
                            regs[rd][8*i +: 8] = dmem[int'(w[31:0]) + i];
                end
                OP_STORE, OP_STORER:
                begin
                    w = (f == OP_STORE) ? imm : a;
                    if (!addr_valid(w))
                        st = ST_BADADDR;
                    else
                        for (int i = 0; i < 8; i++)
                            dmem[int'(w[31:0]) + i] = regs[rd][8*i +: 8];
                end
                OP_INC:    begin regs[rd] = regs[rd] + 64'd1; set_flags(regs[rd]); end
                OP_DEC:    begin regs[rd] = regs[rd] - 64'd1; set_flags(regs[rd]); end
                OP_NOP:    ;
                OP_HALT:   st = ST_HALT;
                default:   st = ST_UNKNOWN;
            endcase
            if (take)
                pc = target;
            if (st != ST_OK)
                halted = 1'b1;
        end
        r.status = st;
        r.pc     = pc;
        r.zf     = zflag;
        r.nf     = nflag;
        r.value  = regs[rd];
    endtask

    task automatic report(string what, logic [63:0] want, logic [63:0] got);
        $display("mismatch at result %0d: %s expected %h got %h", beats_out, what, want, got);
        errors++;
    endtask

    // result side: sample, then pick the next ready level
    initial
    begin
        retire_t want;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (retire_q.size() == 0)
                begin
                    $display("result beat with nothing pending: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = retire_q.pop_front();
                    if (m_tdata[2:0] != want.status)
                        report("status", 64'(want.status), 64'(m_tdata[2:0]));
                    if (m_tdata[66:3] != want.pc)
                        report("next_pc", want.pc, m_tdata[66:3]);
                    if (m_tdata[67] != want.zf)
                        report("zero", 64'(want.zf), 64'(m_tdata[67]));
                    if (m_tdata[68] != want.nf)
                        report("negative", 64'(want.nf), 64'(m_tdata[68]));
                    if (m_tdata[132:69] != want.value)
                        report("dest_value", want.value, m_tdata[132:69]);
                end
                beats_out++;
            end
            if (hold_off > 0)
            begin
                hold_off--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                hold_off = $urandom_range(0, 12);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send(logic [9:0] f, logic [4:0] rd, ra, rb, logic [31:0] imm);
        retire_t r;
        logic [63:0] beat;
        beat = {7'd0, imm, rb, ra, rd, f};
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do
            @(posedge clk);
        while (!s_tready);
        execute(beat, r);
        retire_q.push_back(r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (retire_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_start_pc(logic [63:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        pc = v;
    endtask

    task automatic test_directed();
        send(OP_LOADI, 5'd1, 5'd0, 5'd0, 32'h7FFF_FFFF);
        send(OP_LOADI, 5'd2, 5'd0, 5'd0, 32'h8000_0000);
        send(OP_LOADI, 5'd3, 5'd0, 5'd0, 32'hFFFF_FFFF);
        send(OP_MOV,   5'd4, 5'd2, 5'd0, 32'd0);
        send(OP_MULT,  5'd5, 5'd2, 5'd4, 32'd0);
        send(OP_ADD,   5'd5, 5'd5, 5'd5, 32'd0);
        send(OP_DIV,   5'd6, 5'd5, 5'd3, 32'd0);
        send(OP_DIV,   5'd7, 5'd1, 5'd2, 32'd0);
        send(OP_SUB,   5'd8, 5'd1, 5'd1, 32'd0);
        send(OP_BREQ,  5'd0, 5'd0, 5'd0, 32'hFFFF_FFFE);
        send(OP_CMP,   5'd0, 5'd2, 5'd1, 32'd0);
        send(OP_BRLT,  5'd0, 5'd0, 5'd0, 32'd5);
        send(OP_BRGT,  5'd0, 5'd0, 5'd0, 32'd5);
        send(OP_BRLE,  5'd0, 5'd0, 5'd0, 32'h8000_0000);
        send(OP_BRGE,  5'd0, 5'd0, 5'd0, 32'd3);
        send(OP_BRZERO, 5'd0, 5'd0, 5'd0, 32'd3);
        send(OP_BRNEG, 5'd0, 5'd0, 5'd0, 32'h7FFF_FFFF);
        send(OP_BR,    5'd0, 5'd0, 5'd0, 32'hFFFF_FFF0);
        send(OP_STORE, 5'd5, 5'd0, 5'd0, 32'd0);
        send(OP_STORE, 5'd3, 5'd0, 5'd0, 32'(DMEM_BYTES - 8));
        send(OP_LOADA, 5'd9, 5'd0, 5'd0, 32'd3);
        send(OP_STORER, 5'd1, 5'd9, 5'd0, 32'd0);
        send(OP_LOADR, 5'd10, 5'd9, 5'd0, 32'd0);
        send(OP_LOAD,  5'd11, 5'd0, 5'd0, 32'(DMEM_BYTES - 8));
        send(OP_INC,   5'd3, 5'd0, 5'd0, 32'd0);
        send(OP_DEC,   5'd3, 5'd0, 5'd0, 32'd0);
        send(OP_NOP,   5'd0, 5'd0, 5'd0, 32'd0);
    endtask

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 2))
            0:       return 32'(8 * $urandom_range(0, 15));
            1:       return 32'($urandom_range(0, 63));
            default: return 32'($urandom_range(0, DMEM_BYTES - 8));
        endcase
    endfunction

    function automatic logic [31:0] pick_imm();
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'($urandom_range(0, 3)) - 32'd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_op();
        op_t        op;
        logic [4:0] rd, ra, rb;
        logic [31:0] imm;
        op  = op_t'($urandom_range(0, 22));
        rd  = 5'($urandom);
        ra  = 5'($urandom);
        rb  = 5'($urandom);
        imm = pick_imm();
        case (op)
            OP_DIV:
                if (regs[rb] == 64'd0)
                    send(OP_LOADI, rb, 5'd0, 5'd0, pick_imm() | 32'd1);
            OP_LOAD, OP_STORE:
                imm = pick_addr();
            OP_LOADR, OP_STORER:
                if (!addr_valid(regs[ra]))
                    send(OP_LOADA, ra, 5'($urandom), 5'($urandom), pick_addr());
            default: ;
        endcase
        send(op, rd, ra, rb, imm);
    endtask

    task automatic test_random(int n);
        repeat (n)
            random_op();
    endtask

    task automatic test_backpressure();
        hold_off = 400;
        repeat (40)
            random_op();
        drain();
    endtask

    task automatic test_stop();
        case ($urandom_range(0, 3))
            0: send(OP_HALT, 5'($urandom), 5'd0, 5'd0, $urandom);
            1:
            begin
                send(OP_LOADI, 5'd31, 5'd0, 5'd0, 32'd0);
                send(OP_DIV, 5'd1, 5'd2, 5'd31, 32'd0);
            end
            2: send(OP_LOAD, 5'd1, 5'd0, 5'd0,
                    ($urandom_range(0, 1) != 0) ? 32'(DMEM_BYTES - 7) : 32'hFFFF_FFF8);
            default: send(10'($urandom_range(24, 1023)), 5'd1, 5'd2, 5'd3, $urandom);
        endcase
        repeat (60)
            send(10'($urandom), 5'($urandom), 5'($urandom), 5'($urandom), $urandom);
    endtask

    initial
    begin
        errors    = 0;
        beats_out = 0;
        hold_off  = 0;
        quiet     = 1'b0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        foreach (regs[i])
            regs[i] = '0;
        foreach (dmem[i])
            dmem[i] = '0;
        zflag  = 1'b0;
        nflag  = 1'b0;
        pc     = '0;
        halted = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        write_start_pc(64'hFFFF_FFFF_FFFF_FFF0);
        test_directed();
        write_start_pc(64'd0);
        test_random(RAND_ITEMS / 3);
        test_backpressure();
        write_start_pc(64'hFFFF_FFFF_FFFF_FFFF);
        test_random(RAND_ITEMS / 3);
        write_start_pc({$urandom, $urandom});
        test_random(RAND_ITEMS / 3);
        drain();
        quiet = 1'b1;
        test_stop();
        drain();
        repeat (100) @(posedge clk);

        $display("covered %0d results over all opcodes, start_pc extremes, stalls and a stop",
                 beats_out);
        $display("opcode counts: div %0d mult %0d load %0d store %0d loadr %0d storer %0d",
                 kind_seen[OP_DIV], kind_seen[OP_MULT], kind_seen[OP_LOAD],
                 kind_seen[OP_STORE], kind_seen[OP_LOADR], kind_seen[OP_STORER]);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
